// ----- rtl/jfs_pkg.sv -----
// shared types and constants of the joint force split and break check
package jfs_pkg;

  localparam int unsigned FIX_W    = 32;
  localparam int unsigned CFG_W    = 31;
  localparam int unsigned DMG_W    = 18;
  localparam int unsigned STRESS_W = 17;
  localparam int unsigned SQRT_W   = 64;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned U_QW     = 31;
  localparam int unsigned R_QW     = 16;

  localparam logic [STRESS_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [CFG_W-1:0] TENSION_RST     = 31'd1280000;
  localparam logic [CFG_W-1:0] COMPRESSION_RST = 31'd12800000;
  localparam logic [CFG_W-1:0] SHEAR_RST       = 31'd512000;
  localparam logic [CFG_W-1:0] TWIST_RST       = 31'd128000;

  typedef enum logic [1:0] {
    CFG_TENSION,
    CFG_COMPRESSION,
    CFG_SHEAR,
    CFG_TWIST
  } cfg_idx_e;

  typedef struct packed {
    logic signed [FIX_W-1:0] force_x;
    logic signed [FIX_W-1:0] force_y;
    logic signed [FIX_W-1:0] force_z;
    logic signed [FIX_W-1:0] axis_x;
    logic signed [FIX_W-1:0] axis_y;
    logic signed [FIX_W-1:0] axis_z;
    logic signed [FIX_W-1:0] arm_x;
    logic signed [FIX_W-1:0] arm_y;
    logic signed [FIX_W-1:0] arm_z;
    logic [DMG_W-1:0]        damage;
  } in_t;

  typedef struct packed {
    logic signed [FIX_W-1:0] axial_force;
    logic signed [FIX_W-1:0] shear_x;
    logic signed [FIX_W-1:0] shear_y;
    logic signed [FIX_W-1:0] shear_z;
    logic signed [FIX_W-1:0] torsion;
    logic                    breaks;
    logic [STRESS_W-1:0]     stress_level;
  } out_t;

endpackage

// ----- rtl/joint_force_split_and_break_check.sv -----
// top level: force split into axial, shear and torsion with break check
//
// usage
// - input channel in_valid_i / in_stall_o / in_data_i carries one joint per
//   transaction: force, axis of any length, moment arm and damage
// - output channel out_valid_o / out_stall_i / out_data_o carries the axial
//   force, shear vector, torsion, break flag and stress level
// - four limit registers are written through cfg_we_i / cfg_idx_i /
//   cfg_data_i; write them only while no transaction is in flight
// - throughput is one transaction per cycle unless a held result stalls the pipeline
// - most of the pipeline depth comes from two 32-stage square roots (axis
//   length, shear length), the 31-stage dividers that normalize the axis and the
//   16-stage dividers that form the load ratios
// - a stalled output freezes the whole pipeline in the same cycle, so
//   in_stall_o follows out_stall_i while a result is waiting; nothing is
//   dropped or repeated
// - reset clears all valid bits and loads the limits with their defaults
module joint_force_split_and_break_check import jfs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned SQ_LAT = SQRT_W / 2;
  localparam int unsigned LAT    = 6 + SQ_LAT + 1 + U_QW + 10 + SQ_LAT + 1 + R_QW + 1;

  // side data around the axis length root and the normalizing divider
  typedef struct packed {
    logic [2:0][31:0] f;
    logic [2:0][55:0] tm;
    logic [2:0]       tn;
    logic [2:0]       an;
    logic [2:0][31:0] sc;
    logic             zero;
    logic [DMG_W-1:0] dmg;
  } side1_t;

  // side data around the shear length root
  typedef struct packed {
    logic [32:0]      axm;
    logic             axp;
    logic [58:0]      torm;
    logic [4:0][31:0] sat;
    logic [DMG_W-1:0] dmg;
  } side3_t;

  // side data around the ratio dividers
  typedef struct packed {
    logic [4:0][31:0]    sat;
    logic                brk;
    logic [2:0]          ge;
    logic [STRESS_W-1:0] dmgc;
  } side4_t;

  function automatic logic [4:0] norm_shift(logic [31:0] m);
    logic [4:0] k;
    k = '0;
    for (int i = 0; i <= 30; i++) begin
      if (m[i]) k = 5'(30 - i);
    end
    return k;
  endfunction

  // truncating shifts toward zero
  function automatic logic signed [63:0] tdiv8(logic signed [63:0] x);
    logic signed [63:0] b;
    b = x + (x[63] ? 64'sd255 : 64'sd0);
    return b >>> 8;
  endfunction

  function automatic logic signed [89:0] tdiv30(logic signed [89:0] x);
    logic signed [89:0] b;
    b = x + (x[89] ? 90'sd1073741823 : 90'sd0);
    return b >>> 30;
  endfunction

  function automatic logic [31:0] sat32(logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sd2147483647)       r = 32'h7fffffff;
    else if (x < -64'sd2147483648) r = 32'h80000000;
    else                           r = x[31:0];
    return r;
  endfunction

  // limit registers
  logic [CFG_W-1:0] lim_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q[CFG_TENSION]     <= TENSION_RST;
      lim_q[CFG_COMPRESSION] <= COMPRESSION_RST;
      lim_q[CFG_SHEAR]       <= SHEAR_RST;
      lim_q[CFG_TWIST]       <= TWIST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TENSION:     lim_q[CFG_TENSION]     <= cfg_data_i;
        CFG_COMPRESSION: lim_q[CFG_COMPRESSION] <= cfg_data_i;
        CFG_SHEAR:       lim_q[CFG_SHEAR]       <= cfg_data_i;
        CFG_TWIST:       lim_q[CFG_TWIST]       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // whole pipeline advances together unless a finished result is held
  logic           adv;
  logic [LAT-1:0] vld_q;

  assign adv         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // input unpacking
  logic [2:0][31:0] fin, ain, rin;

  always_comb begin
    fin = {in_data_i.force_z, in_data_i.force_y, in_data_i.force_x};
    ain = {in_data_i.axis_z, in_data_i.axis_y, in_data_i.axis_x};
    rin = {in_data_i.arm_z, in_data_i.arm_y, in_data_i.arm_x};
  end

  // stages 1 to 6: axis magnitudes, normalizing shift, squared length;
  // cross products in parallel
  logic [2:0][31:0]   f1_q, r1_q, am1_q, f2_q, am2_q, f3_q, am3_q, f4_q, sc4_q, f5_q, sc5_q;
  logic [2:0]         an1_q, an2_q, an3_q, an4_q, an5_q, tn5_q;
  logic [DMG_W-1:0]   dmg1_q, dmg2_q, dmg3_q, dmg4_q, dmg5_q;
  logic [31:0]        m2_q;
  logic [5:0][63:0]   cp2_q;
  logic [5:0][55:0]   cd3_q;
  logic [4:0]         k3_q;
  logic               zero3_q, zero4_q, zero5_q;
  logic [2:0][56:0]   t4_q;
  logic [2:0][55:0]   tm5_q;
  logic [2:0][63:0]   sq5_q;
  logic [63:0]        sum6_q;
  side1_t             sd6_q;
  logic [31:0]        mx12;

  always_comb begin
    mx12 = (am1_q[0] > am1_q[1]) ? am1_q[0] : am1_q[1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1
      for (int i = 0; i < 3; i++) begin
        f1_q[i]  <= fin[i];
        r1_q[i]  <= rin[i];
        an1_q[i] <= ain[i][31];
        am1_q[i] <= ain[i][31] ? (~ain[i] + 32'd1) : ain[i];
      end
      dmg1_q <= in_data_i.damage;
      // stage 2
      m2_q     <= (mx12 > am1_q[2]) ? mx12 : am1_q[2];
      cp2_q[0] <= $signed(r1_q[1]) * $signed(f1_q[2]);
      cp2_q[1] <= $signed(r1_q[2]) * $signed(f1_q[1]);
      cp2_q[2] <= $signed(r1_q[2]) * $signed(f1_q[0]);
      cp2_q[3] <= $signed(r1_q[0]) * $signed(f1_q[2]);
      cp2_q[4] <= $signed(r1_q[0]) * $signed(f1_q[1]);
      cp2_q[5] <= $signed(r1_q[1]) * $signed(f1_q[0]);
      f2_q     <= f1_q;
      am2_q    <= am1_q;
      an2_q    <= an1_q;
      dmg2_q   <= dmg1_q;
      // stage 3
      for (int j = 0; j < 6; j++) begin
        cd3_q[j] <= 56'(tdiv8($signed(cp2_q[j])));
      end
      k3_q    <= norm_shift(m2_q);
      zero3_q <= (m2_q == '0);
      f3_q    <= f2_q;
      am3_q   <= am2_q;
      an3_q   <= an2_q;
      dmg3_q  <= dmg2_q;
      // stage 4
      t4_q[0] <= $signed(cd3_q[0]) - $signed(cd3_q[1]);
      t4_q[1] <= $signed(cd3_q[2]) - $signed(cd3_q[3]);
      t4_q[2] <= $signed(cd3_q[4]) - $signed(cd3_q[5]);
      for (int i = 0; i < 3; i++) begin
        sc4_q[i] <= am3_q[i] << k3_q;
      end
      zero4_q <= zero3_q;
      f4_q    <= f3_q;
      an4_q   <= an3_q;
      dmg4_q  <= dmg3_q;
      // stage 5
      for (int i = 0; i < 3; i++) begin
        tm5_q[i] <= t4_q[i][56] ? 56'(-$signed(t4_q[i])) : t4_q[i][55:0];
        tn5_q[i] <= t4_q[i][56];
        sq5_q[i] <= 64'(sc4_q[i]) * 64'(sc4_q[i]);
      end
      sc5_q   <= sc4_q;
      zero5_q <= zero4_q;
      f5_q    <= f4_q;
      an5_q   <= an4_q;
      dmg5_q  <= dmg4_q;
      // stage 6
      sum6_q     <= sq5_q[0] + sq5_q[1] + sq5_q[2];
      sd6_q.f    <= f5_q;
      sd6_q.tm   <= tm5_q;
      sd6_q.tn   <= tn5_q;
      sd6_q.an   <= an5_q;
      sd6_q.sc   <= sc5_q;
      sd6_q.zero <= zero5_q;
      sd6_q.dmg  <= dmg5_q;
    end
  end

  // axis length, rounded up
  logic [LEN_W-1:0] len_root;
  logic             len_nz;
  logic [$bits(side1_t)-1:0] sd38;

  jfs_isqrt #(.W(SQRT_W)) u_len_sqrt (
    .clk_i   (clk_i),
    .en_i    (adv),
    .rad_i   (sum6_q),
    .root_o  (len_root),
    .rem_nz_o(len_nz)
  );

  jfs_delay #(.W($bits(side1_t)), .N(SQ_LAT)) u_len_dly (
    .clk_i(clk_i),
    .en_i (adv),
    .d_i  (sd6_q),
    .q_o  (sd38)
  );

  logic [LEN_W-1:0] len39_q;
  side1_t           sd39_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      len39_q <= len_root + LEN_W'(len_nz);
      sd39_q  <= side1_t'(sd38);
    end
  end

  // unit axis, one divider per component
  logic [2:0][U_QW-1:0]      uq;
  logic [$bits(side1_t)-1:0] sd70_raw;
  side1_t                    sd70;

  for (genvar c = 0; c < 3; c++) begin : g_unit
    jfs_div #(.DW(LEN_W), .QW(U_QW)) u_div (
      .clk_i(clk_i),
      .en_i (adv),
      .hi_i ({1'b0, sd39_q.sc[c][31:1]}),
      .lo_i ({sd39_q.sc[c][0], {(U_QW-1){1'b0}}}),
      .den_i(len39_q),
      .quo_o(uq[c])
    );
  end

  jfs_delay #(.W($bits(side1_t)), .N(U_QW)) u_unit_dly (
    .clk_i(clk_i),
    .en_i (adv),
    .d_i  (sd39_q),
    .q_o  (sd70_raw)
  );

  assign sd70 = side1_t'(sd70_raw);

  // stages 71 to 80: axial, torsion, shear and its squared length
  logic [2:0][30:0]   um71_q, um72_q;
  logic [2:0]         un71_q, ts72_q, ts73_q;
  logic [2:0][31:0]   us71_q, us72_q, us73_q, us74_q;
  logic [2:0][31:0]   f71_q, f72_q, f73_q, f74_q, f75_q, f76_q;
  logic [2:0][55:0]   tm71_q;
  logic [2:0]         tn71_q;
  logic [DMG_W-1:0]   dmg71_q, dmg72_q, dmg73_q, dmg74_q, dmg75_q, dmg76_q, dmg77_q;
  logic [2:0][63:0]   fu72_q;
  logic [2:0][58:0]   tph72_q, tpl72_q;
  logic [63:0]        fs73_q;
  logic [2:0][86:0]   tp73_q;
  logic [33:0]        ax74_q, ax75_q, ax76_q, ax77_q;
  logic [2:0][87:0]   tsg74_q;
  logic [2:0][65:0]   ua75_q;
  logic [89:0]        tsum75_q;
  logic [2:0][35:0]   sp76_q;
  logic [59:0]        tor76_q, tor77_q;
  logic [2:0][36:0]   s77_q;
  logic [2:0][31:0]   cm78_q;
  logic [2:0][63:0]   p79_q;
  side3_t             sd78_q, sd79_q, sd80_q;
  logic [63:0]        sq80_q;
  logic [2:0][36:0]   smag;
  logic [65:0]        psum;
  logic [63:0]        fsb;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      smag[i] = s77_q[i][36] ? 37'(-$signed(s77_q[i])) : s77_q[i];
    end
    psum = 66'(p79_q[0]) + 66'(p79_q[1]) + 66'(p79_q[2]);
    fsb  = $signed(fs73_q) + (fs73_q[63] ? 64'sd1073741823 : 64'sd0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 71: signed unit axis, zero for a zero axis
      for (int i = 0; i < 3; i++) begin
        um71_q[i] <= sd70.zero ? '0 : uq[i];
        us71_q[i] <= sd70.zero ? '0 :
                     (sd70.an[i] ? (~{1'b0, uq[i]} + 32'd1) : {1'b0, uq[i]});
      end
      un71_q  <= sd70.an;
      f71_q   <= sd70.f;
      tm71_q  <= sd70.tm;
      tn71_q  <= sd70.tn;
      dmg71_q <= sd70.dmg;
      // stage 72: dot product terms and split torque products
      for (int i = 0; i < 3; i++) begin
        fu72_q[i]  <= $signed(f71_q[i]) * $signed(us71_q[i]);
        tph72_q[i] <= 59'(tm71_q[i][55:28]) * 59'(um71_q[i]);
        tpl72_q[i] <= 59'(tm71_q[i][27:0]) * 59'(um71_q[i]);
        ts72_q[i]  <= tn71_q[i] ^ un71_q[i];
      end
      um72_q  <= um71_q;
      us72_q  <= us71_q;
      f72_q   <= f71_q;
      dmg72_q <= dmg71_q;
      // stage 73
      fs73_q <= $signed(fu72_q[0]) + $signed(fu72_q[1]) + $signed(fu72_q[2]);
      for (int i = 0; i < 3; i++) begin
        tp73_q[i] <= {tph72_q[i], 28'b0} + 87'(tpl72_q[i]);
      end
      ts73_q  <= ts72_q;
      us73_q  <= us72_q;
      f73_q   <= f72_q;
      dmg73_q <= dmg72_q;
      // stage 74: axial force
      ax74_q <= 34'($signed(fsb) >>> 30);
      for (int i = 0; i < 3; i++) begin
        tsg74_q[i] <= ts73_q[i] ? 88'(-$signed({1'b0, tp73_q[i]})) : {1'b0, tp73_q[i]};
      end
      us74_q  <= us73_q;
      f74_q   <= f73_q;
      dmg74_q <= dmg73_q;
      // stage 75
      for (int i = 0; i < 3; i++) begin
        ua75_q[i] <= $signed(us74_q[i]) * $signed(ax74_q);
      end
      tsum75_q <= $signed(tsg74_q[0]) + $signed(tsg74_q[1]) + $signed(tsg74_q[2]);
      ax75_q   <= ax74_q;
      f75_q    <= f74_q;
      dmg75_q  <= dmg74_q;
      // stage 76
      for (int i = 0; i < 3; i++) begin
        sp76_q[i] <= 36'(tdiv30($signed(ua75_q[i])));
      end
      tor76_q <= 60'(tdiv30($signed(tsum75_q)));
      ax76_q  <= ax75_q;
      f76_q   <= f75_q;
      dmg76_q <= dmg75_q;
      // stage 77: shear vector
      for (int i = 0; i < 3; i++) begin
        s77_q[i] <= $signed(f76_q[i]) - $signed(sp76_q[i]);
      end
      tor77_q <= tor76_q;
      ax77_q  <= ax76_q;
      dmg77_q <= dmg76_q;
      // stage 78: magnitudes, clamps and saturated outputs
      for (int i = 0; i < 3; i++) begin
        cm78_q[i]       <= (|smag[i][36:32]) ? 32'hffffffff : smag[i][31:0];
        sd78_q.sat[i+1] <= sat32(64'($signed(s77_q[i])));
      end
      sd78_q.sat[0] <= sat32(64'($signed(ax77_q)));
      sd78_q.sat[4] <= sat32(64'($signed(tor77_q)));
      sd78_q.axm    <= ax77_q[33] ? 33'(-$signed(ax77_q)) : ax77_q[32:0];
      sd78_q.axp    <= !ax77_q[33] && (|ax77_q);
      sd78_q.torm   <= tor77_q[59] ? 59'(-$signed(tor77_q)) : tor77_q[58:0];
      sd78_q.dmg    <= dmg77_q;
      // stage 79
      for (int i = 0; i < 3; i++) begin
        p79_q[i] <= 64'(cm78_q[i]) * 64'(cm78_q[i]);
      end
      sd79_q <= sd78_q;
      // stage 80: saturating sum of squares
      sq80_q <= (|psum[65:64]) ? '1 : psum[63:0];
      sd80_q <= sd79_q;
    end
  end

  // shear length
  logic [31:0]               shm;
  logic [$bits(side3_t)-1:0] sd112_raw;
  side3_t                    sd112;

  jfs_isqrt #(.W(SQRT_W)) u_shear_sqrt (
    .clk_i   (clk_i),
    .en_i    (adv),
    .rad_i   (sq80_q),
    .root_o  (shm),
    .rem_nz_o()
  );

  jfs_delay #(.W($bits(side3_t)), .N(SQ_LAT)) u_shear_dly (
    .clk_i(clk_i),
    .en_i (adv),
    .d_i  (sd80_q),
    .q_o  (sd112_raw)
  );

  assign sd112 = side3_t'(sd112_raw);

  // stage 113: break test and ratio divider setup
  logic [CFG_W-1:0]         ax_lim;
  logic [2:0][CFG_W-1:0]    ld113_q, lim113_q;
  side4_t                   sd113_q;

  assign ax_lim = sd112.axp ? lim_q[CFG_TENSION] : lim_q[CFG_COMPRESSION];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ld113_q[0]  <= sd112.axm[CFG_W-1:0];
      ld113_q[1]  <= shm[CFG_W-1:0];
      ld113_q[2]  <= sd112.torm[CFG_W-1:0];
      lim113_q[0] <= ax_lim;
      lim113_q[1] <= lim_q[CFG_SHEAR];
      lim113_q[2] <= lim_q[CFG_TWIST];
      sd113_q.ge[0] <= sd112.axm >= 33'(ax_lim);
      sd113_q.ge[1] <= shm >= 32'(lim_q[CFG_SHEAR]);
      sd113_q.ge[2] <= sd112.torm >= 59'(lim_q[CFG_TWIST]);
      sd113_q.brk   <= (sd112.axm > 33'(ax_lim)) ||
                       (shm > 32'(lim_q[CFG_SHEAR])) ||
                       (sd112.torm > 59'(lim_q[CFG_TWIST])) ||
                       (|sd112.dmg[DMG_W-1:16]);
      sd113_q.dmgc  <= (|sd112.dmg[DMG_W-1:16]) ? ONE_Q16 : STRESS_W'(sd112.dmg[15:0]);
      sd113_q.sat   <= sd112.sat;
    end
  end

  // load ratios; a load at or above its limit is handled by the ge flags
  logic [2:0][R_QW-1:0]      rq;
  logic [$bits(side4_t)-1:0] sd129_raw;
  side4_t                    sd129;

  for (genvar c = 0; c < 3; c++) begin : g_ratio
    jfs_div #(.DW(CFG_W), .QW(R_QW)) u_div (
      .clk_i(clk_i),
      .en_i (adv),
      .hi_i (ld113_q[c]),
      .lo_i ('0),
      .den_i(lim113_q[c]),
      .quo_o(rq[c])
    );
  end

  jfs_delay #(.W($bits(side4_t)), .N(R_QW)) u_ratio_dly (
    .clk_i(clk_i),
    .en_i (adv),
    .d_i  (sd113_q),
    .q_o  (sd129_raw)
  );

  assign sd129 = side4_t'(sd129_raw);

  // stage 130: stress level and output register
  logic [2:0][STRESS_W-1:0] rat;
  logic [STRESS_W-1:0]      st_a, st_b;
  out_t                     out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rat[i] = sd129.ge[i] ? ONE_Q16 : {1'b0, rq[i]};
    end
    st_a = (rat[0] > rat[1]) ? rat[0] : rat[1];
    st_b = (rat[2] > sd129.dmgc) ? rat[2] : sd129.dmgc;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.axial_force  <= sd129.sat[0];
      out_q.shear_x      <= sd129.sat[1];
      out_q.shear_y      <= sd129.sat[2];
      out_q.shear_z      <= sd129.sat[3];
      out_q.torsion      <= sd129.sat[4];
      out_q.breaks       <= sd129.brk;
      out_q.stress_level <= (st_a > st_b) ? st_a : st_b;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- rtl/jfs_isqrt.sv -----
// pipelined integer square root, one result bit per stage
module jfs_isqrt import jfs_pkg::*; #(
  parameter int unsigned W = SQRT_W
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [W-1:0]   rad_i,
  output logic [W/2-1:0] root_o,
  output logic           rem_nz_o
);

  localparam int unsigned NS = W / 2;

  logic [W-1:0] r_q [NS];
  logic [W-1:0] v_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * s);
    logic [W-1:0] r_in, v_in, trial, r_d, v_d;

    always_comb begin
      r_in  = (s == 0) ? '0 : r_q[(s == 0) ? 0 : s - 1];
      v_in  = (s == 0) ? rad_i : v_q[(s == 0) ? 0 : s - 1];
      trial = r_in + BIT;
      if (v_in >= trial) begin
        v_d = v_in - trial;
        r_d = (r_in >> 1) + BIT;
      end else begin
        v_d = v_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s] <= r_d;
        v_q[s] <= v_d;
      end
    end
  end

  assign root_o   = r_q[NS-1][W/2-1:0];
  assign rem_nz_o = |v_q[NS-1];

endmodule

// ----- rtl/jfs_div.sv -----
// pipelined restoring divider, one quotient bit per stage; hi must be below den
module jfs_div import jfs_pkg::*; #(
  parameter int unsigned DW = LEN_W,
  parameter int unsigned QW = U_QW
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] hi_i,
  input  logic [QW-1:0] lo_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] sh_q  [QW];
  logic [DW-1:0] den_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW-1:0] rem_in, den_in;
    logic [QW-1:0] sh_in;
    logic [DW:0]   rem2;
    logic          take;

    always_comb begin
      rem_in = (s == 0) ? hi_i  : rem_q[(s == 0) ? 0 : s - 1];
      sh_in  = (s == 0) ? lo_i  : sh_q[(s == 0) ? 0 : s - 1];
      den_in = (s == 0) ? den_i : den_q[(s == 0) ? 0 : s - 1];
      rem2   = {rem_in, sh_in[QW-1]};
      take   = rem2 >= {1'b0, den_in};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= take ? DW'(rem2 - {1'b0, den_in}) : rem2[DW-1:0];
        sh_q[s]  <= {sh_in[QW-2:0], take};
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o = sh_q[QW-1];

endmodule

// ----- rtl/jfs_delay.sv -----
// enabled register chain that keeps side data in step with a pipelined unit
module jfs_delay import jfs_pkg::*; #(
  parameter int unsigned W = FIX_W,
  parameter int unsigned N = R_QW
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[N-1];

endmodule

// ----- rtl/jfs_checker.sv -----
// port level checks for the joint force split and break check
module jfs_checker import jfs_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("held result changed");

  // input side stalls only behind a held result
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall not tied to output stall");

  // a broken joint is fully stressed
  a_break_stress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.breaks |-> out_data_o.stress_level == ONE_Q16)
    else $error("break without full stress");

  // stress never passes one
  a_stress_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.stress_level <= ONE_Q16)
    else $error("stress above one");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid out of reset");

endmodule

bind joint_force_split_and_break_check jfs_checker u_jfs_checker (.*);
